@@ sv/tpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Tree path distance package
// Shared widths, operation codes and the queued item record.
// ----------------------------------------------------------------------------
`default_nettype none

package tpd_pkg;

  localparam int NODE_W      = 12;
  localparam int DEPTH_W     = 12;
  localparam int IN_WEIGHT_W = 16;
  localparam int SUM_W       = 32;
  localparam int TABLE_DEPTH = 4096;
  localparam int S_TDATA_W   = 80;
  localparam int M_TDATA_W   = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                   operation;
    logic [NODE_W-1:0]      node;
    logic [NODE_W-1:0]      parent_node;
    logic [DEPTH_W-1:0]     node_depth;
    logic [IN_WEIGHT_W-1:0] edge_weight;
    logic [NODE_W-1:0]      query_from;
    logic [NODE_W-1:0]      query_to;
  } item_t;

endpackage

`default_nettype wire

@@ sv/tpd_front.sv @@
// ----------------------------------------------------------------------------
// Tree path distance front end
// Accepts input transactions, unpacks them into item records and holds them
// in a short queue until the walker takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_front
  import tpd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  input  wire logic                 s_tuser,
  output logic                      item_valid,
  input  wire logic                 item_ready,
  output item_t                     item
);

  item_t                 queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QPTR_W:0]       count;
  item_t                 in_item;
  logic                  push;
  logic                  pop;

  always_comb begin
    in_item.operation   = s_tuser;
    in_item.node        = s_tdata[11:0];
    in_item.parent_node = s_tdata[23:12];
    in_item.node_depth  = s_tdata[35:24];
    in_item.edge_weight = s_tdata[51:36];
    in_item.query_from  = s_tdata[63:52];
    in_item.query_to    = s_tdata[75:64];
  end

  assign s_tready   = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign item_valid = (count != '0);
  assign item       = queue[rd_ptr];
  assign push       = s_tvalid && s_tready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/tpd_back.sv @@
// ----------------------------------------------------------------------------
// Tree path distance back end
// Holds the node tables in memory, applies table writes and walks both
// query cursors up to their lowest common ancestor, one level per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_back
  import tpd_pkg::*;
#(
  parameter int MAX_NODES   = 4096,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  input  wire item_t                item,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,
  output logic                      m_tuser
);

  localparam int WS      = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
  localparam int ENTRY_W = NODE_W + DEPTH_W + WS;
  localparam int STEP_W  = $clog2(MAX_NODES + 1);
  localparam int ADDR_W  = $clog2(TABLE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic [ENTRY_W-1:0] table_mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_a;
  logic [ENTRY_W-1:0] rd_b;
  logic [ADDR_W-1:0]  rd_addr_a;
  logic [ADDR_W-1:0]  rd_addr_b;

  logic               state;
  logic [NODE_W-1:0]  cursor_a;
  logic [NODE_W-1:0]  cursor_b;
  logic [SUM_W-1:0]   sum_a;
  logic [SUM_W-1:0]   sum_b;
  logic [STEP_W-1:0]  steps;
  logic               sat;

  logic [NODE_W-1:0]  parent_a;
  logic [NODE_W-1:0]  parent_b;
  logic [DEPTH_W-1:0] depth_a;
  logic [DEPTH_W-1:0] depth_b;
  logic [WS-1:0]      weight_a;
  logic [WS-1:0]      weight_b;
  logic               step_a;
  logic               step_b;
  logic [SUM_W:0]     add_a;
  logic [SUM_W:0]     add_b;
  logic [SUM_W:0]     add_total;
  logic [NODE_W-1:0]  cursor_a_next;
  logic [NODE_W-1:0]  cursor_b_next;
  logic               meet;
  logic               limit;
  logic               advance;
  logic               out_free;
  logic               take;
  logic               result_load;

  assign parent_a = rd_a[ENTRY_W-1 -: NODE_W];
  assign parent_b = rd_b[ENTRY_W-1 -: NODE_W];
  assign depth_a  = rd_a[WS +: DEPTH_W];
  assign depth_b  = rd_b[WS +: DEPTH_W];
  assign weight_a = rd_a[WS-1:0];
  assign weight_b = rd_b[WS-1:0];

  assign step_a    = (depth_a >= depth_b);
  assign step_b    = (depth_b >= depth_a);
  assign add_a     = {1'b0, sum_a} + (SUM_W+1)'(weight_a);
  assign add_b     = {1'b0, sum_b} + (SUM_W+1)'(weight_b);
  assign add_total = {1'b0, sum_a} + {1'b0, sum_b};

  assign cursor_a_next = step_a ? parent_a : cursor_a;
  assign cursor_b_next = step_b ? parent_b : cursor_b;

  assign meet     = (cursor_a == cursor_b);
  assign limit    = (steps >= STEP_W'(MAX_NODES));
  assign advance  = (state == ST_WALK) && !meet && !limit;
  assign out_free = !m_tvalid || m_tready;

  assign result_load = (state == ST_WALK) && (meet || limit) && out_free;

  assign item_ready = (state == ST_IDLE);
  assign take       = item_valid && item_ready;

  always_comb begin
    if (state == ST_IDLE) begin
      rd_addr_a = ADDR_W'(item.query_from);
      rd_addr_b = ADDR_W'(item.query_to);
    end else if (advance) begin
      rd_addr_a = ADDR_W'(cursor_a_next);
      rd_addr_b = ADDR_W'(cursor_b_next);
    end else begin
      rd_addr_a = ADDR_W'(cursor_a);
      rd_addr_b = ADDR_W'(cursor_b);
    end
  end

  always_ff @(posedge clk) begin
    if (take && (item.operation == OP_WRITE)) begin
      table_mem[ADDR_W'(item.node)] <= {item.parent_node, item.node_depth,
                                        item.edge_weight[WS-1:0]};
    end
    rd_a <= table_mem[rd_addr_a];
    rd_b <= table_mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cursor_a <= '0;
      cursor_b <= '0;
      sum_a    <= '0;
      sum_b    <= '0;
      steps    <= '0;
      sat      <= 1'b0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tuser  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !result_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take && (item.operation == OP_QUERY)) begin
            cursor_a <= item.query_from;
            cursor_b <= item.query_to;
            sum_a    <= '0;
            sum_b    <= '0;
            steps    <= '0;
            sat      <= 1'b0;
            state    <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (meet) begin
            if (out_free) begin
              m_tvalid <= 1'b1;
              m_tdata  <= add_total[SUM_W] ? '1 : add_total[SUM_W-1:0];
              m_tuser  <= sat || add_total[SUM_W];
              state    <= ST_IDLE;
            end
          end else if (limit) begin
            if (out_free) begin
              m_tvalid <= 1'b1;
              m_tdata  <= '0;
              m_tuser  <= 1'b1;
              state    <= ST_IDLE;
            end
          end else begin
            if (step_a) begin
              sum_a <= add_a[SUM_W] ? '1 : add_a[SUM_W-1:0];
            end
            if (step_b) begin
              sum_b <= add_b[SUM_W] ? '1 : add_b[SUM_W-1:0];
            end
            sat      <= sat || (step_a && add_a[SUM_W]) || (step_b && add_b[SUM_W]);
            cursor_a <= cursor_a_next;
            cursor_b <= cursor_b_next;
            steps    <= steps + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/tree_path_distance_query.sv @@
// ----------------------------------------------------------------------------
// Tree path distance query
// Stores a rooted weighted tree node by node and answers path distance
// queries by climbing both endpoints to their lowest common ancestor.
//
//   Channel  Direction  tdata                         tuser
//   s_*      in         node, parent_node, node_depth, operation
//                       edge_weight, query_from,
//                       query_to
//   m_*      out        path_distance                 query_error
//
// A table write leaves the walker idle and ready for the next item. A query
// climbs one level per step, the step count being the number of edges on the
// longer side of the path up to the common ancestor, capped at MAX_NODES; the
// node tables are read through registered reads, one level per cycle.
// Reset clears the queue, the walker and the result register; table contents
// stay undefined until written. A four-deep queue keeps accepting
// transactions while a result waits for m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_path_distance_query
  import tpd_pkg::*;
#(
  parameter int MAX_NODES   = 4096,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // node, parent_node, node_depth, edge_weight, query_from, query_to, zero pad
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // operation
  input  wire logic                 s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // path_distance
  output logic [M_TDATA_W-1:0]      m_tdata,
  // query_error
  output logic                      m_tuser
);

  item_t item;
  logic  item_valid;
  logic  item_ready;

  tpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  tpd_back #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

@@ sv/tpd_checker.sv @@
// ----------------------------------------------------------------------------
// Tree path distance port checker
// Watches the top-level ports for reset behaviour and result stability.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_checker
  import tpd_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata,
  input wire logic                 m_tuser
);

  // A stalled result transaction keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Reset empties the queue and the result register.
  a_reset: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not empty after reset");

  // No result can leave before a transaction has passed through the queue.
  a_latency: assert property (@(posedge clk)
    rst |=> !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)
    else $error("result appeared too soon after reset");

  // No result appears just after reset while no input transaction is offered.
  a_input_idle: assert property (@(posedge clk)
    rst ##1 !rst && !s_tvalid |=> !m_tvalid)
    else $error("result without any input transaction");

endmodule

bind tree_path_distance_query tpd_checker u_tpd_checker (.*);

`default_nettype wire
